// ----- hdl/skit_pkg.sv -----
// ============================================================================
// skit_pkg - shared types and codes for the sorted key index table
// Holds the request and response beat layouts, the table entry layout and
// the request and status codes.
// ============================================================================
package skit_pkg;

    localparam int KEY_W  = 31;
    localparam int SLOT_W = 4;
    localparam int STAT_W = 3;

    // Request type codes
    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_LOOKUP = 1'b1;

    // Response status codes
    localparam logic [STAT_W-1:0] ST_INSERTED = 3'd0;
    localparam logic [STAT_W-1:0] ST_DUP      = 3'd1;
    localparam logic [STAT_W-1:0] ST_FULL     = 3'd2;
    localparam logic [STAT_W-1:0] ST_HIT      = 3'd3;
    localparam logic [STAT_W-1:0] ST_MISS     = 3'd4;

    typedef logic [KEY_W-1:0]  t_key;
    typedef logic [SLOT_W-1:0] t_slot;

    typedef struct packed {
        logic req_type;
        t_key key;
    } t_req;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        t_slot             record_slot;
        t_slot             sorted_rank;
    } t_rsp;

    // One table entry: key and the record slot it was given
    typedef struct packed {
        t_key  key;
        t_slot slot;
    } t_entry;

endpackage

// ----- hdl/sorted_key_index_table.sv -----
// ============================================================================
// sorted_key_index_table - sorted key table with insert and lookup
// Keeps keys in ascending order in a RAM, each paired with the record slot
// it got on insert. Inserts refuse duplicates and a full table; lookups
// report the record slot and sorted rank of a present key.
// ============================================================================
//
//  Channel   Ports                       Handshake
//  --------  --------------------------  ---------------------------------
//  request   i_req (t_req)               beat taken when start & !busy
//  response  o_result (t_rsp)            beat valid while o_done, 1 cycle
//
//  Sequence: a lookup walks the table from entry 0 through one RAM read
//  port, one entry a cycle, and stops at the first key not below the request
//  key or at the last entry. An insert scans to its insert point the same
//  way. When larger entries follow, a shift pass moves each of them up by
//  one, from the last entry down (the first read is primed in the last scan
//  cycle), and S_PLACE then writes the new entry. An insert into an empty
//  table skips the scan and goes straight to S_PLACE.
//  Reset clears the state, done flag and entry count, not the RAM; no RAM
//  clearing pass is needed since only entries below the count are ever used.
//  The response is a single-cycle strobe; the receiver cannot stall it.
//  busy drops in the cycle the response beat is shown, so the next request
//  beat may be taken in that cycle.
// ============================================================================
module sorted_key_index_table
    import skit_pkg::*;
#(
    parameter int TABLE_DEPTH = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    input  t_req i_req,
    output logic busy,
    output logic o_done,
    output t_rsp o_result
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int EW = $bits(t_entry);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT,
        S_PLACE
    } t_state;

    t_state          r_state, n_state;
    logic [CW-1:0]   r_count, n_count;
    logic [AW-1:0]   r_idx,   n_idx;    // index of the entry on the read data
    logic [AW-1:0]   r_ins,   n_ins;    // insert position
    t_req            r_req,   n_req;
    logic            r_done,  n_done;
    t_rsp            r_result, n_result;

    logic            ram_we;
    logic [AW-1:0]   ram_waddr;
    t_entry          ram_wdata;
    logic [AW-1:0]   ram_raddr;
    logic [EW-1:0]   ram_rdata;
    t_entry          rd;
    logic            scan_last;
    logic            scan_above;
    logic            tbl_full;

    skit_ram #(
        .WIDTH (EW),
        .DEPTH (TABLE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign rd         = t_entry'(ram_rdata);
    assign scan_last  = (CW'(r_idx) + CW'(1)) == r_count;
    assign scan_above = rd.key > r_req.key;
    assign tbl_full   = r_count == CW'(TABLE_DEPTH);

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_idx     = r_idx;
        n_ins     = r_ins;
        n_req     = r_req;
        n_done    = 1'b0;
        n_result  = r_result;
        ram_we    = 1'b0;
        ram_waddr = r_ins;
        ram_wdata.key  = r_req.key;
        ram_wdata.slot = t_slot'(r_count);
        ram_raddr = '0;

        case (r_state)
            S_IDLE: begin
                // Start the walk at entry 0
                if (start) begin
                    n_req = i_req;
                    n_idx = '0;
                    n_ins = '0;
                    if (r_count == '0) begin
                        if (i_req.req_type == REQ_LOOKUP) begin
                            n_done               = 1'b1;
                            n_result.status      = ST_MISS;
                            n_result.record_slot = '0;
                            n_result.sorted_rank = '0;
                        end else begin
                            n_state = S_PLACE;
                        end
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end

            S_SCAN: begin
                if (rd.key == r_req.key) begin
                    // Key present: hit or duplicate
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                    if (r_req.req_type == REQ_LOOKUP) begin
                        n_result.status      = ST_HIT;
                        n_result.record_slot = rd.slot;
                        n_result.sorted_rank = t_slot'(r_idx);
                    end else begin
                        n_result.status      = ST_DUP;
                        n_result.record_slot = '0;
                        n_result.sorted_rank = '0;
                    end
                end else if (scan_above || scan_last) begin
                    // Key absent; insert point is here or past the end
                    n_ins = scan_above ? r_idx : AW'(r_count);
                    if (r_req.req_type == REQ_LOOKUP || tbl_full) begin
                        n_done               = 1'b1;
                        n_state              = S_IDLE;
                        n_result.status      = (r_req.req_type == REQ_LOOKUP) ?
                                               ST_MISS : ST_FULL;
                        n_result.record_slot = '0;
                        n_result.sorted_rank = '0;
                    end else if (!scan_above) begin
                        n_state = S_PLACE;
                    end else begin
                        // Prime the shift with the last entry
                        n_idx     = AW'(r_count - CW'(1));
                        ram_raddr = AW'(r_count - CW'(1));
                        n_state   = S_SHIFT;
                    end
                end else begin
                    // Advance to the next entry
                    n_idx     = r_idx + AW'(1);
                    ram_raddr = r_idx + AW'(1);
                end
            end

            S_SHIFT: begin
                // Move the entry on the read data up by one slot
                ram_we    = 1'b1;
                ram_waddr = r_idx + AW'(1);
                ram_wdata = rd;
                if (r_idx == r_ins) begin
                    n_state = S_PLACE;
                end else begin
                    n_idx     = r_idx - AW'(1);
                    ram_raddr = r_idx - AW'(1);
                end
            end

            S_PLACE: begin
                // Write the new entry and report it
                ram_we               = 1'b1;
                n_count              = r_count + CW'(1);
                n_done               = 1'b1;
                n_state              = S_IDLE;
                n_result.status      = ST_INSERTED;
                n_result.record_slot = t_slot'(r_count);
                n_result.sorted_rank = t_slot'(r_ins);
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_done  <= n_done;
        end
        r_idx    <= n_idx;
        r_ins    <= n_ins;
        r_req    <= n_req;
        r_result <= n_result;
    end

    assign busy     = r_state != S_IDLE;
    assign o_done   = r_done;
    assign o_result = r_result;

endmodule

// ----- hdl/skit_ram.sv -----
// ============================================================================
// skit_ram - generic simple dual-port RAM
// One write port, one read port, read data registered.
// ============================================================================
module skit_ram #(
    parameter int WIDTH = 35,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata <= mem[i_raddr];
    end

endmodule
